>>> src/mpm_pkg.sv
// Shared types and constants for the multi-pattern payload matcher.
// No dependencies; imported by every module under src.
package mpm_pkg;

    localparam int NUM_PATTERNS    = 8;
    localparam int MAX_PATTERN_LEN = 16;
    localparam int LEN_W           = $clog2(MAX_PATTERN_LEN + 1);
    localparam int POS_W           = $clog2(MAX_PATTERN_LEN);
    localparam int INDEX_W         = 3;
    localparam int BYTE_POS_W      = 4;
    localparam int HIT_MASK_W      = 8;

    typedef enum logic [1:0] {
        OP_PAT_BYTE = 2'd0,
        OP_PAT_LEN  = 2'd1,
        OP_PAYLOAD  = 2'd2
    } opcode_t;

    typedef logic [7:0]                                   byte_t;
    typedef logic [LEN_W-1:0]                             len_t;
    typedef logic [MAX_PATTERN_LEN-1:0][7:0]              pat_row_t;
    typedef pat_row_t [NUM_PATTERNS-1:0]                  pat_table_t;
    typedef logic [NUM_PATTERNS-1:0][LEN_W-1:0]           len_table_t;
    typedef logic [NUM_PATTERNS-1:0]                      hit_vec_t;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [INDEX_W-1:0]    pattern_index;
        logic [BYTE_POS_W-1:0] byte_position;
        byte_t                 value;
        logic                  last_byte;
        logic [31:0]           source_address;
        logic [31:0]           dest_address;
    } cmd_t;

    typedef struct packed {
        logic [HIT_MASK_W-1:0] hit_mask;
        logic [31:0]           alert_source;
        logic [31:0]           alert_dest;
    } alert_t;

    // Table write request from the input stage
    typedef struct packed {
        logic                  byte_we;
        logic                  len_we;
        logic [INDEX_W-1:0]    index;
        logic [BYTE_POS_W-1:0] pos;
        byte_t                 value;
    } tbl_wr_t;

    // Scan status back to the top level
    typedef struct packed {
        hit_vec_t hits;
        logic     packet_open;
    } scan_stat_t;

endpackage

>>> src/mpm_table.sv
// Pattern table: pattern bytes and pattern lengths in flip-flops.
// Depends on mpm_pkg.
module mpm_table (
    input  logic               clk,
    input  logic               rst_n,
    input  mpm_pkg::tbl_wr_t   wr,
    output mpm_pkg::pat_table_t pat_bytes,
    output mpm_pkg::len_table_t pat_lens
);
    import mpm_pkg::*;

    pat_table_t pat_bytes_reg;
    len_table_t pat_lens_reg;
    len_t       len_sat;

    assign len_sat = (int'(wr.value) > MAX_PATTERN_LEN) ? LEN_W'(MAX_PATTERN_LEN)
                                                         : LEN_W'(wr.value);

    // Pattern bytes are undefined until loaded, so no reset
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            for (int j = 0; j < MAX_PATTERN_LEN; j++)
            begin
                if (wr.byte_we && int'(wr.index) == p && int'(wr.pos) == j)
                begin
                    pat_bytes_reg[p][j] <= wr.value;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lens_reg <= '0;
        end
        else
        begin
            for (int p = 0; p < NUM_PATTERNS; p++)
            begin
                if (wr.len_we && int'(wr.index) == p)
                begin
                    pat_lens_reg[p] <= len_sat;
                end
            end
        end
    end

    assign pat_bytes = pat_bytes_reg;
    assign pat_lens  = pat_lens_reg;

endmodule

>>> src/mpm_scan.sv
// Payload scanner: byte window, packet byte count, sticky hits and the
// parallel tail compare of every pattern. Depends on mpm_pkg.
module mpm_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  mpm_pkg::byte_t      value,
    input  logic                last_byte,
    input  mpm_pkg::pat_table_t pat_bytes,
    input  mpm_pkg::len_table_t pat_lens,
    output mpm_pkg::scan_stat_t stat
);
    import mpm_pkg::*;

    pat_row_t window_reg;
    pat_row_t window_next;
    len_t     seen_reg;
    len_t     seen_next;
    hit_vec_t sticky_reg;
    hit_vec_t hit_now;
    logic [NUM_PATTERNS-1:0][MAX_PATTERN_LEN-1:0] byte_ok;

    always_comb
    begin
        window_next[0] = value;
        for (int k = 1; k < MAX_PATTERN_LEN; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
        seen_next = (seen_reg < LEN_W'(MAX_PATTERN_LEN)) ? seen_reg + 1'b1 : seen_reg;
    end

    // Pattern byte j lines up with window slot len-1-j (slot 0 is newest)
    for (genvar p = 0; p < NUM_PATTERNS; p++)
    begin : g_pat
        for (genvar j = 0; j < MAX_PATTERN_LEN; j++)
        begin : g_byte
            logic [POS_W-1:0] sel;
            assign sel = POS_W'(pat_lens[p] - LEN_W'(j) - LEN_W'(1));
            assign byte_ok[p][j] = (LEN_W'(j) >= pat_lens[p])
                                || (pat_bytes[p][j] == window_next[sel]);
        end
        assign hit_now[p] = (pat_lens[p] != '0) && (pat_lens[p] <= seen_next)
                         && (&byte_ok[p]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            seen_reg   <= '0;
            sticky_reg <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                window_reg <= '0;
                seen_reg   <= '0;
                sticky_reg <= '0;
            end
            else
            begin
                window_reg <= window_next;
                seen_reg   <= seen_next;
                sticky_reg <= sticky_reg | hit_now;
            end
        end
    end

    assign stat.hits        = sticky_reg | hit_now;
    assign stat.packet_open = (seen_reg != '0);

endmodule

>>> src/multi_pattern_payload_matcher.sv
// Top level of the multi-pattern payload matcher: input register, pattern
// table, scanner and alert register. Depends on mpm_pkg, mpm_table, mpm_scan.
//
//  channel | direction | handshake               | payload
//  cmd     | in        | cmd_valid / cmd_stall     | cmd   (mpm_pkg::cmd_t)
//  alert   | out       | alert_valid / alert_stall | alert (mpm_pkg::alert_t)
//
// One request per cycle unless stalled; the last byte loads the alert register.
// The table, window and hit logic sit between the input and alert registers.
// rst_n clears lengths, window, count and hits; pattern bytes stay unknown.
// alert_stall holds the alert register; the input register still drains into
// it when it is empty or being taken, so cmd_stall only rises if both are full.
module multi_pattern_payload_matcher (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  mpm_pkg::cmd_t   cmd,
    output logic            alert_valid,
    input  logic            alert_stall,
    output mpm_pkg::alert_t alert
);
    import mpm_pkg::*;

    logic       in_valid_reg;
    cmd_t       in_item_reg;
    logic       out_valid_reg;
    alert_t     out_item_reg;
    logic       out_ready;
    logic       advance;
    logic       is_payload;
    logic       report;
    tbl_wr_t    tbl_wr;
    pat_table_t pat_bytes;
    len_table_t pat_lens;
    scan_stat_t scan_stat;
    logic [HIT_MASK_W-1:0] hit_mask;

    assign out_ready  = !out_valid_reg || !alert_stall;
    assign advance    = in_valid_reg && out_ready;
    assign cmd_stall  = in_valid_reg && !out_ready;
    assign is_payload = (in_item_reg.opcode == OP_PAYLOAD);
    assign report     = is_payload && in_item_reg.last_byte;

    always_comb
    begin
        tbl_wr.byte_we = advance && (in_item_reg.opcode == OP_PAT_BYTE);
        tbl_wr.len_we  = advance && (in_item_reg.opcode == OP_PAT_LEN);
        tbl_wr.index   = in_item_reg.pattern_index;
        tbl_wr.pos     = in_item_reg.byte_position;
        tbl_wr.value   = in_item_reg.value;
    end

    mpm_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (tbl_wr),
        .pat_bytes (pat_bytes),
        .pat_lens  (pat_lens)
    );

    mpm_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance && is_payload),
        .value     (in_item_reg.value),
        .last_byte (in_item_reg.last_byte),
        .pat_bytes (pat_bytes),
        .pat_lens  (pat_lens),
        .stat      (scan_stat)
    );

    // Patterns beyond the mask width are matched but not reported
    for (genvar i = 0; i < HIT_MASK_W; i++)
    begin : g_mask
        if (i < NUM_PATTERNS)
        begin : g_used
            assign hit_mask[i] = scan_stat.hits[i];
        end
        else
        begin : g_pad
            assign hit_mask[i] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd_stall && cmd_valid)
        begin
            in_item_reg <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= advance && report;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && report)
        begin
            out_item_reg.hit_mask     <= hit_mask;
            out_item_reg.alert_source <= in_item_reg.source_address;
            out_item_reg.alert_dest   <= in_item_reg.dest_address;
        end
    end

    assign alert_valid = out_valid_reg;
    assign alert       = out_item_reg;

`ifndef SYNTH
    // A new alert only follows a last payload byte leaving the input register
    a_alert_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && report))
        else $error("alert raised without a last payload byte");

    // Per-packet state is cleared once the packet is reported
    a_packet_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && report) |=> !scan_stat.packet_open)
        else $error("scan state not cleared after report");

    // A held request is neither dropped nor overwritten
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("held request lost");
`endif

endmodule
